// ===== hw/rtl/nri_pkg.sv =====
// nri_pkg: shared types and constants of the newline record indexer
// used by nri_front, nri_fifo, nri_back and newline_record_indexer
// no dependencies
package nri_pkg;

    // field and register widths
    localparam int unsigned BYTE_BITS      = 8;
    localparam int unsigned TS_BITS        = 63;
    localparam int unsigned CFG_DATA_BITS  = 63;
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CTR_BITS       = 64;
    localparam int unsigned OFFSET_BITS    = 44;
    localparam int unsigned TIME_BITS      = 48;
    localparam int unsigned LENGTH_BITS    = 20;
    localparam int unsigned META_BITS      = 16;

    localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'h0a;

    // meta flag bits
    localparam logic [META_BITS-1:0] FLAG_STDERR     = 16'h0001;
    localparam logic [META_BITS-1:0] FLAG_NO_NEWLINE = 16'h0002;
    localparam logic [META_BITS-1:0] FLAG_TRUNCATED  = 16'h0008;

    // register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BASE_TIME    = 2'd0,
        REG_START_OFFSET = 2'd1
    } reg_index_t;

    // input word
    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 from_stderr;
        logic                 write_end;
        logic [TS_BITS-1:0]   timestamp_us;
    } in_t;

    // result word
    typedef struct packed {
        logic [OFFSET_BITS-1:0] record_offset;
        logic [LENGTH_BITS-1:0] length_minus_one;
        logic [TIME_BITS-1:0]   time_delta;
        logic [META_BITS-1:0]   meta_flags;
        logic                   status;
    } out_t;

    // closed record as classified by the front end
    typedef struct packed {
        logic                   offset_ovf;
        logic [OFFSET_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0] len_m1;
        logic                   truncated;
        logic                   from_stderr;
        logic                   no_newline;
        logic [TS_BITS-1:0]     timestamp_us;
    } rec_t;

endpackage

// ===== hw/rtl/newline_record_indexer.sv =====
// newline_record_indexer: top level of the log record indexer
// depends on nri_pkg, nri_front, nri_fifo, nri_back
//
// Usage:
//   s_valid/s_ready/s_data carry one log byte per word with its stderr and
//   end-of-write marks and the current time. A newline byte, or the last byte
//   of a write, closes a record and produces one index entry on
//   m_valid/m_ready/m_data; other bytes produce nothing.
//   cfg_wr_en/cfg_index/cfg_data write base_time_us (index 0) or start_offset
//   (index 1); other indexes are ignored. Writing start_offset
//   reloads the byte counters and drops any open record. Write only when idle.
// Timing:
//   one byte per cycle while the record queue is not full; the front end updates
//   its counters per accepted byte and a two-entry record queue feeds the back end,
//   which does one 64-bit subtract and compare per entry into the output register.
//   An entry passes through the record queue and then the output register before m_valid.
// Reset and stall:
//   aresetn (synchronous, active low) clears counters, base time, m_valid and queue; m_data is not reset.
//   While m_ready is low the output holds; the queue absorbs two more records,
//   after which s_ready drops until the receiver drains.
module newline_record_indexer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [nri_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nri_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  nri_pkg::in_t                       s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output nri_pkg::out_t                      m_data
);
    import nri_pkg::*;

    rec_t push_data;
    rec_t pop_data;
    logic push;
    logic pop;
    logic q_full;
    logic q_not_empty;

    // byte intake and record classification
    nri_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .q_push      (push),
        .q_push_data (push_data)
    );

    // record queue
    nri_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    // entry formatting and output register
    nri_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .q_pop_data  (pop_data),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== hw/rtl/nri_front.sv =====
// nri_front: accepts log bytes, tracks offsets and record length, emits closed records
// depends on nri_pkg
module nri_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [nri_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nri_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  nri_pkg::in_t                       s_data,
    input  logic                               q_full,
    output logic                               q_push,
    output nri_pkg::rec_t                      q_push_data
);
    import nri_pkg::*;

    localparam logic [LENGTH_BITS:0] LEN_CAP = {1'b1, {LENGTH_BITS{1'b0}}};

    logic [CTR_BITS-1:0]  next_offset_reg, next_offset_next;
    logic [CTR_BITS-1:0]  record_start_reg, record_start_next;
    logic [LENGTH_BITS:0] record_length_reg, record_length_next;
    logic [CTR_BITS-1:0]  offset_inc;
    logic                 accept;
    logic                 is_nl;
    logic                 closing;
    logic                 cfg_start;
    logic                 truncated;

    assign s_ready = !q_full;

    // classify the incoming word
    always_comb begin
        accept    = s_valid && s_ready;
        is_nl     = s_data.data_byte == NEWLINE_BYTE;
        closing   = is_nl || s_data.write_end;
        cfg_start = cfg_wr_en && (cfg_index == REG_START_OFFSET);
        truncated = record_length_reg >= LEN_CAP;
        if (next_offset_reg != {CTR_BITS{1'b1}}) begin
            offset_inc = next_offset_reg + {{(CTR_BITS-1){1'b0}}, 1'b1};
        end else begin
            offset_inc = next_offset_reg;
        end
    end

    // counter updates
    always_comb begin
        next_offset_next   = next_offset_reg;
        record_start_next  = record_start_reg;
        record_length_next = record_length_reg;
        if (cfg_start) begin
            next_offset_next   = {1'b0, cfg_data};
            record_start_next  = {1'b0, cfg_data};
            record_length_next = '0;
        end else if (accept) begin
            next_offset_next = offset_inc;
            if (closing) begin
                record_start_next  = offset_inc;
                record_length_next = '0;
            end else if (record_length_reg <= LEN_CAP) begin
                record_length_next = record_length_reg + {{LENGTH_BITS{1'b0}}, 1'b1};
            end
        end
    end

    // record descriptor; length after this word is old length plus one, saturated
    always_comb begin
        q_push                   = accept && closing;
        q_push_data.offset_ovf   = |record_start_reg[CTR_BITS-1:OFFSET_BITS];
        q_push_data.offset       = record_start_reg[OFFSET_BITS-1:0];
        q_push_data.len_m1       = truncated ? {LENGTH_BITS{1'b1}}
                                             : record_length_reg[LENGTH_BITS-1:0];
        q_push_data.truncated    = truncated;
        q_push_data.from_stderr  = s_data.from_stderr;
        q_push_data.no_newline   = !is_nl;
        q_push_data.timestamp_us = s_data.timestamp_us;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_offset_reg   <= '0;
            record_start_reg  <= '0;
            record_length_reg <= '0;
        end else begin
            next_offset_reg   <= next_offset_next;
            record_start_reg  <= record_start_next;
            record_length_reg <= record_length_next;
        end
    end

    // length never runs past one above the cap
    assert property (@(posedge aclk) disable iff (!aresetn)
        record_length_reg <= LEN_CAP + 1'b1)
        else $error("record length beyond saturation point");

    // a closing word starts a fresh record
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> record_length_reg == '0)
        else $error("record length not cleared after close");

    // offset advances by one per accepted word until it saturates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_start && next_offset_reg != {CTR_BITS{1'b1}})
        |=> next_offset_reg == $past(next_offset_reg) + 1'b1)
        else $error("byte offset did not advance");

endmodule

// ===== hw/rtl/nri_fifo.sv =====
// nri_fifo: two-entry record queue between front and back ends
// depends on nri_pkg
module nri_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  nri_pkg::rec_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output nri_pkg::rec_t pop_data
);
    import nri_pkg::*;

    localparam int unsigned DEPTH    = 2;
    localparam int unsigned PTR_BITS = $clog2(DEPTH);
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

    rec_t                mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = count_reg == CNT_BITS'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        do_push     = push && !full;
        do_pop      = pop && not_empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // fill count stays within the queue depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("record queue overfilled");

endmodule

// ===== hw/rtl/nri_back.sv =====
// nri_back: turns queued records into index entries in the output register
// depends on nri_pkg
module nri_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [nri_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nri_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               q_not_empty,
    input  nri_pkg::rec_t                      q_pop_data,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output nri_pkg::out_t                      m_data
);
    import nri_pkg::*;

    logic [CFG_DATA_BITS-1:0] base_time_reg;
    logic                     m_valid_reg, m_valid_next;
    out_t                     m_data_reg, m_data_next;
    logic [TS_BITS:0]         diff;
    logic                     before_base;
    logic                     delta_ovf;
    logic [META_BITS-1:0]     meta;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // time delta, overflow check and meta flags
    always_comb begin
        diff        = {1'b0, q_pop_data.timestamp_us} - {1'b0, base_time_reg};
        before_base = diff[TS_BITS];
        delta_ovf   = !before_base && (|diff[TS_BITS-1:TIME_BITS]);
        meta        = '0;
        if (q_pop_data.from_stderr) begin
            meta = meta | FLAG_STDERR;
        end
        if (q_pop_data.no_newline) begin
            meta = meta | FLAG_NO_NEWLINE;
        end
        if (q_pop_data.truncated) begin
            meta = meta | FLAG_TRUNCATED;
        end
    end

    // load the output register when it is empty or being drained; else drop valid on drain
    always_comb begin
        q_pop        = q_not_empty && (!m_valid_reg || m_ready);
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
            if (q_pop_data.offset_ovf || delta_ovf) begin
                m_data_next        = '0;
                m_data_next.status = 1'b1;
            end else begin
                m_data_next.record_offset    = q_pop_data.offset;
                m_data_next.length_minus_one = q_pop_data.len_m1;
                m_data_next.time_delta       = before_base ? '0 : diff[TIME_BITS-1:0];
                m_data_next.meta_flags       = meta;
                m_data_next.status           = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            base_time_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && (cfg_index == REG_BASE_TIME)) begin
                base_time_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
